>>> rtl/core/isdt_pkg.sv
// ----------------------------------------------------------------------------
// isdt_pkg
// Shared types and codes of the interval set table.
// ----------------------------------------------------------------------------
package isdt_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned FrameW = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [FrameW-1:0] range_start;
    logic [FrameW-1:0] range_end;
    logic [IdxW-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              entry_valid;
    logic [FrameW-1:0] entry_start;
    logic [FrameW-1:0] entry_end;
    logic [CountW-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic load;
    logic walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic edit;
    logic walk_end;
  } stat_t;

endpackage

>>> rtl/core/isdt_ram.sv
// ----------------------------------------------------------------------------
// isdt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module isdt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/isdt_ctrl.sv
// ----------------------------------------------------------------------------
// isdt_ctrl
// Sequencer of the interval set table: accept, load, walk, finish.
// ----------------------------------------------------------------------------
module isdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  isdt_pkg::stat_t   stat_i,
  output isdt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = stat_i.edit ? ST_WALK : ST_FINISH;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("result not shown after finish");

  a_walk_only_edit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && !stat_i.edit) |=> state_q == ST_FINISH)
    else $error("walk entered without an edit");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

endmodule

>>> rtl/core/isdt_dp.sv
// ----------------------------------------------------------------------------
// isdt_dp
// Datapath: two table banks in one RAM, walk logic, commit and result.
// ----------------------------------------------------------------------------
module isdt_dp #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  isdt_pkg::cmd_t      cmd_i,
  output isdt_pkg::stat_t     stat_o,
  input  isdt_pkg::in_item_t  in_item_i,
  output isdt_pkg::out_item_t out_item_o
);

  localparam int unsigned IW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned NW = $clog2(TableDepth + 2);
  localparam int unsigned FW = isdt_pkg::FrameW;

  isdt_pkg::in_item_t  op_q;
  isdt_pkg::out_item_t res_q, res_d;
  logic [IW-1:0] i_q, i_d;
  logic [NW-1:0] n_q, n_d;
  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] ns_q, ns_d, ne_q, ne_d;
  logic          merged_q, merged_d, placed_q, placed_d, sub_q, sub_d, bank_q, bank_d;

  logic [2*FW-1:0] rdata, wdata;
  logic [IW:0]     raddr, waddr;
  logic            wr, we, adv;
  logic [FW-1:0]   a, b, ws, wend, lo_end, hi_start;
  logic            is_ins, is_rem, range_ok, ov, lo, hi, last;

  assign a        = rdata[2*FW-1:FW];
  assign b        = rdata[FW-1:0];
  assign is_ins   = (op_q.mode == isdt_pkg::MODE_INSERT);
  assign is_rem   = (op_q.mode == isdt_pkg::MODE_REMOVE);
  assign range_ok = op_q.range_start < op_q.range_end;
  assign ov       = (b > op_q.range_start) && (a <= op_q.range_end);
  assign lo_end   = (b < op_q.range_start) ? b : op_q.range_start;
  assign hi_start = (a > op_q.range_end) ? a : op_q.range_end;
  assign lo       = a < lo_end;
  assign hi       = hi_start < b;
  assign last     = (CW'(i_q) == count_q - CW'(1));

  assign stat_o.edit     = (is_ins || is_rem) && range_ok && (count_q != '0);
  assign stat_o.walk_end = cmd_i.walk && adv && last;

  always_comb begin
    wr       = 1'b0;
    adv      = 1'b0;
    ws       = ns_q;
    wend     = ne_q;
    ns_d     = ns_q;
    ne_d     = ne_q;
    merged_d = merged_q;
    placed_d = placed_q;
    sub_d    = sub_q;
    if (is_ins) begin
      if (ov) begin
        adv      = 1'b1;
        merged_d = 1'b1;
        ns_d     = (a < ns_q) ? a : ns_q;
        ne_d     = (b > ne_q) ? b : ne_q;
      end else if (!placed_q && a > ns_q) begin
        wr       = 1'b1;
        placed_d = 1'b1;
      end else begin
        wr   = 1'b1;
        adv  = 1'b1;
        ws   = a;
        wend = b;
      end
    end else begin
      if (lo && hi && !sub_q) begin
        wr    = 1'b1;
        sub_d = 1'b1;
        ws    = a;
        wend  = lo_end;
      end else if (hi) begin
        wr    = 1'b1;
        adv   = 1'b1;
        sub_d = 1'b0;
        ws    = hi_start;
        wend  = b;
      end else begin
        wr   = lo;
        adv  = 1'b1;
        ws   = a;
        wend = lo_end;
      end
    end
  end

  always_comb begin
    i_d     = i_q;
    n_d     = n_q;
    bank_d  = bank_q;
    count_d = count_q;
    we      = 1'b0;
    wdata   = {ns_q, ne_q};
    raddr   = {bank_q, i_q};
    res_d   = res_q;
    if (cmd_i.start) begin
      i_d = is_ins || is_rem ? '0 : IW'(in_item_i.read_index);
      n_d = '0;
      if (in_item_i.mode != isdt_pkg::MODE_READ) begin
        i_d = '0;
      end else begin
        i_d = IW'(in_item_i.read_index);
      end
    end
    if (cmd_i.walk) begin
      wdata = {ws, wend};
      we    = wr && (n_q < NW'(TableDepth));
      if (wr) begin
        n_d = n_q + NW'(1);
      end
      if (adv) begin
        i_d   = i_q + IW'(1);
        raddr = {bank_q, i_q + IW'(1)};
      end
    end
    if (cmd_i.finish) begin
      res_d             = '0;
      res_d.status      = isdt_pkg::STATUS_DONE;
      case (op_q.mode)
        isdt_pkg::MODE_INSERT, isdt_pkg::MODE_REMOVE: begin
          if (!range_ok) begin
            res_d.status = isdt_pkg::STATUS_BAD_RANGE;
          end else if (is_ins && !merged_q && count_q == CW'(TableDepth)) begin
            res_d.status = isdt_pkg::STATUS_FULL;
          end else if (is_rem && n_q > NW'(TableDepth)) begin
            res_d.status = isdt_pkg::STATUS_FULL;
          end else begin
            bank_d  = !bank_q;
            count_d = CW'(n_q + NW'(is_ins && !placed_q));
            we      = is_ins && !placed_q && (n_q < NW'(TableDepth));
          end
        end
        isdt_pkg::MODE_READ: begin
          if (32'(op_q.read_index) < 32'(count_q)) begin
            res_d.entry_valid = 1'b1;
            res_d.entry_start = a;
            res_d.entry_end   = b;
          end
        end
        default: res_d.status = isdt_pkg::STATUS_DONE;
      endcase
      res_d.entry_count = isdt_pkg::CountW'(count_d);
    end
  end

  assign waddr      = {!bank_q, n_q[IW-1:0]};
  assign out_item_o = res_q;

  isdt_ram #(
    .Width(2 * FW),
    .Depth(2 ** (IW + 1))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      bank_q   <= 1'b0;
      n_q      <= '0;
      i_q      <= '0;
      merged_q <= 1'b0;
      placed_q <= 1'b0;
      sub_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      bank_q  <= bank_d;
      n_q     <= n_d;
      i_q     <= i_d;
      if (cmd_i.start) begin
        merged_q <= 1'b0;
        placed_q <= 1'b0;
        sub_q    <= 1'b0;
      end else if (cmd_i.walk) begin
        merged_q <= merged_d;
        placed_q <= placed_d;
        sub_q    <= sub_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q <= in_item_i;
      ns_q <= in_item_i.range_start;
      ne_q <= in_item_i.range_end;
    end else if (cmd_i.walk) begin
      ns_q <= ns_d;
      ne_q <= ne_d;
    end
    res_q <= res_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TableDepth)
    else $error("stored count above table depth");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= TableDepth + 1)
    else $error("fill index overran");

  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> $past(cmd_i.finish))
    else $error("bank swapped outside commit");

endmodule

>>> rtl/core/interval_set_table_core.sv
// ----------------------------------------------------------------------------
// interval_set_table_core
// Sorted table of disjoint half-open frame ranges with insert, remove, read.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o   | isdt_pkg::in_item_t
// out     | output    | out_valid_o / out_ready_i | isdt_pkg::out_item_t
//
// Read, bad range and unused mode: accept, load, then finish, with no walk.
// Insert and remove walk each entry, plus a step per placement or split,
// set by the single read port walking the old bank into the other bank.
// One item in flight; the next is taken once the result is registered.
// Reset clears the count and the bank select; no clearing pass over the RAM.
// ----------------------------------------------------------------------------
module interval_set_table_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  isdt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output isdt_pkg::out_item_t out_item_o
);

  isdt_pkg::cmd_t  cmd;
  isdt_pkg::stat_t stat;

  isdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  isdt_dp #(
    .TableDepth(TABLE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_item_i (in_item_i),
    .out_item_o(out_item_o)
  );

endmodule

>>> dv/interval_set_table_checker.sv
// ----------------------------------------------------------------------------
// interval_set_table_checker
// Watches both channels of the interval set table, keeps a sorted range table
// of its own, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module interval_set_table_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  isdt_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  isdt_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import isdt_pkg::*;

  logic [FrameW-1:0] tbl_start [TABLE_DEPTH];
  logic [FrameW-1:0] tbl_end   [TABLE_DEPTH];
  int unsigned       tbl_count;
  out_item_t         expected_q [$];

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t         r;
    logic [FrameW-1:0] s, e, ns, ne, a, b, lo, hi;
    logic [FrameW-1:0] ts [TABLE_DEPTH+1];
    logic [FrameW-1:0] te [TABLE_DEPTH+1];
    int unsigned       merged, need, nt;
    bit                placed;
    r = '0;
    nt = 0;
    s = it.range_start;
    e = it.range_end;
    if (it.mode == MODE_INSERT || it.mode == MODE_REMOVE) begin
      if (s >= e) begin
        r.status = STATUS_BAD_RANGE;
      end else if (it.mode == MODE_INSERT) begin
        merged = 0;
        ns = s;
        ne = e;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_end[i] > s && tbl_start[i] <= e) begin
            merged++;
            if (tbl_start[i] < ns) ns = tbl_start[i];
            if (tbl_end[i] > ne) ne = tbl_end[i];
          end
        end
        if (merged == 0 && tbl_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          placed = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (!(tbl_end[i] > s && tbl_start[i] <= e)) begin
              if (!placed && tbl_start[i] > ns && nt < TABLE_DEPTH + 1) begin
                ts[nt] = ns;
                te[nt] = ne;
                nt++;
                placed = 1;
              end
              if (nt < TABLE_DEPTH + 1) begin
                ts[nt] = tbl_start[i];
                te[nt] = tbl_end[i];
                nt++;
              end
            end
          end
          if (!placed && nt < TABLE_DEPTH + 1) begin
            ts[nt] = ns;
            te[nt] = ne;
            nt++;
          end
          r.status = STATUS_DONE;
        end
      end else begin
        need = 0;
        for (int i = 0; i < tbl_count; i++) begin
          a = tbl_start[i];
          b = tbl_end[i];
          lo = (b < s) ? b : s;
          hi = (a > e) ? a : e;
          if (a < lo) begin
            need++;
            if (nt < TABLE_DEPTH + 1) begin
              ts[nt] = a;
              te[nt] = lo;
              nt++;
            end
          end
          if (hi < b) begin
            need++;
            if (nt < TABLE_DEPTH + 1) begin
              ts[nt] = hi;
              te[nt] = b;
              nt++;
            end
          end
        end
        r.status = (need > TABLE_DEPTH) ? STATUS_FULL : STATUS_DONE;
      end
      if (r.status == STATUS_DONE) begin
        for (int i = 0; i < nt && i < TABLE_DEPTH; i++) begin
          tbl_start[i] = ts[i];
          tbl_end[i]   = te[i];
        end
        tbl_count = (nt > TABLE_DEPTH) ? TABLE_DEPTH : nt;
      end
    end else if (it.mode == MODE_READ) begin
      if (it.read_index < tbl_count) begin
        r.entry_valid = 1'b1;
        r.entry_start = tbl_start[it.read_index];
        r.entry_end   = tbl_end[it.read_index];
      end
    end
    r.entry_count = CountW'(tbl_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_item;
    if (!rst_ni) begin
      tbl_count = 0;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) expected_q = {expected_q, apply_item(in_item_i)};
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("item with no prediction waiting: %p", out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.status !== out_item_i.status)
            $error("status exp %0d got %0d", exp_item.status, out_item_i.status);
          if (exp_item.entry_valid !== out_item_i.entry_valid)
            $error("entry_valid exp %0d got %0d", exp_item.entry_valid,
                   out_item_i.entry_valid);
          if (exp_item.entry_start !== out_item_i.entry_start)
            $error("entry_start exp %0h got %0h", exp_item.entry_start,
                   out_item_i.entry_start);
          if (exp_item.entry_end !== out_item_i.entry_end)
            $error("entry_end exp %0h got %0h", exp_item.entry_end, out_item_i.entry_end);
          if (exp_item.entry_count !== out_item_i.entry_count)
            $error("entry_count exp %0d got %0d", exp_item.entry_count,
                   out_item_i.entry_count);
          if (exp_item !== out_item_i) fail_count_o <= fail_count_o + 1;
        end
      end
    end
    pending_o <= expected_q.size();
  end
endmodule

>>> dv/interval_set_table_core_tb.sv
// ----------------------------------------------------------------------------
// interval_set_table_core_tb
// Drives insert, remove and read items into the range table, with directed
// corner cases, clustered random ranges and random stalls on both channels.
// ----------------------------------------------------------------------------
module interval_set_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isdt_pkg::*;

  localparam int unsigned Depth = 16;

  logic      clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, pending;
  bit        calm, hold_out;

  interval_set_table_core #(.TABLE_DEPTH(Depth)) i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_item_i(in_item), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_item_o(out_item)
  );

  interval_set_table_checker #(.TABLE_DEPTH(Depth)) i_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .in_item_i(in_item), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_item_i(out_item), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls unless calm, and a long hold when asked
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_out = 0;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  task automatic send(mode_e m, logic [31:0] s, logic [31:0] e, logic [3:0] idx);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1;
    in_item  <= '{mode: m, range_start: s, range_end: e, read_index: idx};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int unsigned window);
    logic [31:0] s, e;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    s = $urandom_range(0, window);
    e = s + $urandom_range(1, window / 4 + 1);
    if (pick < 4) begin
      s = $urandom();
      e = $urandom();
    end else if (pick < 8) begin
      e = s - $urandom_range(0, 3);
    end
    if (pick < 45) send(MODE_INSERT, s, e, 4'($urandom()));
    else if (pick < 70) send(MODE_REMOVE, s, e, 4'($urandom()));
    else if (pick < 97) send(MODE_READ, $urandom(), $urandom(), 4'($urandom()));
    else send(mode_e'(2'd3), $urandom(), $urandom(), 4'($urandom()));
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_item = '0;
    calm = 0;
    hold_out = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;
    send(MODE_READ, 32'h0, 32'h0, 4'd0);
    send(MODE_INSERT, 32'd5, 32'd5, 4'hf);
    send(MODE_REMOVE, 32'd9, 32'd3, 4'h0);
    send(MODE_INSERT, 32'd10, 32'd20, 4'h0);
    send(MODE_INSERT, 32'd20, 32'd30, 4'h0);
    send(MODE_INSERT, 32'd0, 32'd10, 4'h0);
    send(MODE_INSERT, 32'hffff_fff0, 32'hffff_ffff, 4'h0);
    send(MODE_REMOVE, 32'd12, 32'd14, 4'h0);
    send(MODE_REMOVE, 32'd100, 32'd200, 4'h0);
    send(MODE_REMOVE, 32'd0, 32'd11, 4'h0);
    send(mode_e'(2'd3), 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    for (int i = 0; i < 5; i++) send(MODE_READ, 32'h0, 32'h0, 4'(i));
    send(MODE_READ, 32'h0, 32'h0, 4'hf);
    // fill the table with isolated ranges, then overflow it
    for (int i = 0; i < 17; i++) send(MODE_INSERT, 1000 + 10 * i, 1002 + 10 * i, 4'h0);
    send(MODE_READ, 32'h0, 32'h0, 4'hf);
    send(MODE_REMOVE, 32'd1000, 32'd1001, 4'h0);
    send(MODE_REMOVE, 32'd1000, 32'hffff_ffff, 4'h0);
    hold_out = 1;
    for (int i = 0; i < 6; i++) send_random(200);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 340; i++) begin
      if (i == 300) calm = 1;
      send_random((i % 3 == 0) ? 60 : 400);
    end
    in_valid <= 0;
    while (pending != 0 || out_valid) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
